// ===== hw/rtl/cwa_pkg.sv =====
// Shared types and constants for the centered window average unit.
// Item structs, controller/datapath command and status, and the FSM state type.
// No dependencies.
package cwa_pkg;

	// Default largest window radius
	localparam int MAX_RADIUS_DEF = 31;

	// Field and datapath widths
	localparam int SAMPLE_BITS = 16;
	localparam int SUM_W       = SAMPLE_BITS + 6;
	localparam int RADIUS_W    = 5;
	localparam int WIN_W       = RADIUS_W + 1;
	localparam int AVG_W       = SAMPLE_BITS + 1;
	localparam int AVG_MAX     = (1 << SAMPLE_BITS) - 1;
	localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

	// Input item
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   final_sample;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic signed [AVG_W-1:0] average;
		logic                    run_end;
		logic                    stream_end;
	} result_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV,
		ST_EMIT_C,
		ST_EMIT_T
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic div_step;
		logic emit_center;
		logic emit_trail;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic center_now;
		logic full_now;
		logic trail_now;
		logic div_done;
		logic trail_left;
		logic trail_last;
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/cwa_ctrl.sv =====
// Controller state machine for the centered window average unit.
// Sequences capture, window update, division and result emission.
// Depends on cwa_pkg.
module cwa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            smp_valid,
	input  cwa_pkg::status_t status,
	output logic            smp_ready,
	output cwa_pkg::cmd_t   cmd
);
	import cwa_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (smp_valid) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (status.center_now) begin
					state_d = status.full_now ? ST_DIV : ST_EMIT_C;
				end else begin
					state_d = status.trail_now ? ST_EMIT_T : ST_IDLE;
				end
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_EMIT_C;
			end
			ST_EMIT_C: begin
				if (status.out_free) state_d = status.trail_left ? ST_EMIT_T : ST_IDLE;
			end
			ST_EMIT_T: begin
				if (status.out_free && status.trail_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		smp_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				smp_ready   = 1'b1;
				cmd.capture = smp_valid;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = !status.div_done;
			end
			ST_EMIT_C: begin
				cmd.emit_center = status.out_free;
			end
			ST_EMIT_T: begin
				cmd.emit_trail = status.out_free;
			end
			default: begin
				smp_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/cwa_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Divides the window sum by the window width.
// Depends on cwa_pkg.
module cwa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic                      step,
	input  logic [cwa_pkg::SUM_W-1:0] dividend,
	input  logic [cwa_pkg::WIN_W-1:0] divisor,
	output logic [cwa_pkg::SUM_W-1:0] quotient,
	output logic                      done
);
	import cwa_pkg::*;

	logic [SUM_W-1:0]     dq_q;
	logic [WIN_W-1:0]     rem_q;
	logic [WIN_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WIN_W:0]       shifted;
	logic [WIN_W:0]       diff;
	logic                 fits;

	// One trial subtraction
	assign shifted = {rem_q, dq_q[SUM_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= DIV_CNT_W'(SUM_W);
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift register: dividend bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (load) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step) begin
			dq_q  <= {dq_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
		end
	end

	assign quotient = dq_q;
	assign done     = cnt_q == '0;

endmodule

// ===== hw/rtl/cwa_datapath.sv =====
// Datapath: radius register, sample store, running sum, counters,
// divider and the result register. Depends on cwa_pkg and cwa_div.
module cwa_datapath #(
	parameter int MAX_RADIUS = cwa_pkg::MAX_RADIUS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cwa_pkg::cmd_t                cmd,
	output cwa_pkg::status_t             status,
	input  cwa_pkg::in_item_t            smp_item,
	input  logic                         cfg_valid,
	input  logic [cwa_pkg::RADIUS_W-1:0] cfg_data,
	output logic                         res_valid,
	input  logic                         res_ready,
	output cwa_pkg::result_t             res_item
);
	import cwa_pkg::*;

	localparam int DEPTH    = 2 * MAX_RADIUS + 1;
	localparam int SLOT_W   = $clog2(DEPTH);
	localparam int SEEN_CAP = 2 * MAX_RADIUS + 2;
	localparam int SEEN_W   = $clog2(SEEN_CAP + 1);
	localparam int CMP_W    = ((SEEN_W > WIN_W) ? SEEN_W : WIN_W) + 1;

	logic [RADIUS_W-1:0]    radius_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SEEN_W-1:0]      seen_q;
	logic [SLOT_W-1:0]      wslot_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   fin_q;
	logic [SAMPLE_BITS-1:0] mem_rd_q;
	logic [SAMPLE_BITS-1:0] win_mem_q [DEPTH];
	logic                   full_q;
	logic [RADIUS_W-1:0]    trail_q;
	logic                   res_valid_q;
	result_t                res_q;

	logic [WIN_W-1:0]    win;
	logic [SLOT_W:0]     rd_raw;
	logic [SLOT_W:0]     rd_wrap;
	logic [SLOT_W-1:0]   rd_addr;
	logic [CMP_W-1:0]    n_ext;
	logic [CMP_W-1:0]    n1_ext;
	logic [CMP_W-1:0]    k_ext;
	logic [CMP_W-1:0]    win_ext;
	logic                sub_now;
	logic                center_now;
	logic                full_now;
	logic [RADIUS_W-1:0] trail_val;
	logic [SUM_W-1:0]    new_sum;
	logic [SUM_W-1:0]    quo;
	logic                div_done;
	logic                out_free;
	logic                center_last;
	logic                trail_last;
	logic [AVG_W-1:0]    center_avg;

	// Radius register, writes clamped to the largest radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_W'(1);
		end else if (cfg_valid) begin
			radius_q <= (cfg_data > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : cfg_data;
		end
	end

	// Slot that leaves the window: write slot minus window width, modulo depth
	assign win     = {radius_q, 1'b1};
	assign rd_raw  = {1'b0, wslot_q} + (SLOT_W+1)'(DEPTH) - (SLOT_W+1)'(win);
	assign rd_wrap = rd_raw - (SLOT_W+1)'(DEPTH);
	assign rd_addr = (rd_raw >= (SLOT_W+1)'(DEPTH)) ? rd_wrap[SLOT_W-1:0] : rd_raw[SLOT_W-1:0];

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= smp_item.sample;
			fin_q    <= smp_item.final_sample;
		end
	end

	// Sample store: read on capture, write on update
	always_ff @(posedge clk) begin
		if (cmd.capture) mem_rd_q <= win_mem_q[rd_addr];
		if (cmd.update) win_mem_q[wslot_q] <= sample_q;
	end

	// Window position checks on the count before this sample
	assign n_ext      = CMP_W'(seen_q);
	assign n1_ext     = n_ext + 1'b1;
	assign k_ext      = CMP_W'(radius_q);
	assign win_ext    = CMP_W'(win);
	assign sub_now    = n_ext >= win_ext;
	assign center_now = n_ext >= k_ext;
	assign full_now   = n1_ext >= win_ext;
	assign trail_val  = !fin_q ? '0 :
	                    (n1_ext < k_ext) ? n1_ext[RADIUS_W-1:0] : radius_q;

	// Running sum: drop the oldest sample once the window is full, add the new one
	assign new_sum = sum_q - (sub_now ? SUM_W'(mem_rd_q) : '0) + SUM_W'(sample_q);

	// Stream state; a final sample clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			seen_q  <= '0;
			wslot_q <= '0;
		end else if (cmd.update) begin
			if (fin_q) begin
				sum_q   <= '0;
				seen_q  <= '0;
				wslot_q <= '0;
			end else begin
				sum_q   <= new_sum;
				seen_q  <= (seen_q < SEEN_W'(SEEN_CAP)) ? seen_q + 1'b1 : seen_q;
				wslot_q <= (wslot_q == SLOT_W'(DEPTH - 1)) ? '0 : wslot_q + 1'b1;
			end
		end
	end

	// Per-item result plan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trail_q <= '0;
			full_q  <= 1'b0;
		end else if (cmd.update) begin
			trail_q <= trail_val;
			full_q  <= full_now;
		end else if (cmd.emit_trail) begin
			trail_q <= trail_q - 1'b1;
		end
	end

	// Divider
	cwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.update),
		.step     (cmd.div_step),
		.dividend (new_sum),
		.divisor  (win),
		.quotient (quo),
		.done     (div_done)
	);

	// Center result value, saturated; -1 while the window is not yet full
	always_comb begin
		if (!full_q) begin
			center_avg = '1;
		end else if (quo[SUM_W-1:SAMPLE_BITS] != '0) begin
			center_avg = AVG_W'(AVG_MAX);
		end else begin
			center_avg = {1'b0, quo[SAMPLE_BITS-1:0]};
		end
	end

	assign center_last = trail_q == '0;
	assign trail_last  = trail_q == RADIUS_W'(1);
	assign out_free    = !res_valid_q || res_ready;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit_center || cmd.emit_trail) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_center) begin
			res_q.average    <= center_avg;
			res_q.run_end    <= center_last;
			res_q.stream_end <= fin_q && center_last;
		end else if (cmd.emit_trail) begin
			res_q.average    <= '1;
			res_q.run_end    <= trail_last;
			res_q.stream_end <= fin_q && trail_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Status to the controller
	always_comb begin
		status.center_now = center_now;
		status.full_now   = full_now;
		status.trail_now  = trail_val != '0;
		status.div_done   = div_done;
		status.trail_left = !center_last;
		status.trail_last = trail_last;
		status.out_free   = out_free;
	end

endmodule

// ===== hw/rtl/centered_window_average_unit.sv =====
// Top level of the centered window average unit.
// Joins controller and datapath. Depends on cwa_pkg, cwa_ctrl, cwa_datapath.
//
// channel   dir  handshake               payload
// -------   ---  ---------               -------
// sample    in   smp_valid / smp_ready   smp_item : in_item_t (sample, final_sample)
// result    out  res_valid / res_ready   res_item : result_t (average, run_end, stream_end)
// config    in   cfg_valid / cfg_ready   cfg_data : radius, clamped to MAX_RADIUS
//
// One item at a time. An item that gives no result passes through accept and update.
// An item with a full window passes through accept, update, the divider steps (one
// quotient bit each), a state that sees the divider done, then the register load.
// A partial window skips the divider. Each trailing -1 result after a final
// sample adds one more emit step.
// A result waiting in the output register stalls the controller only when the
// next result is due. Reset clears sum, counters and radius (to 1); the store
// is not cleared.
module centered_window_average_unit #(
	parameter int MAX_RADIUS = cwa_pkg::MAX_RADIUS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         smp_valid,
	output logic                         smp_ready,
	input  cwa_pkg::in_item_t            smp_item,
	output logic                         res_valid,
	input  logic                         res_ready,
	output cwa_pkg::result_t             res_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cwa_pkg::RADIUS_W-1:0] cfg_data
);
	import cwa_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Radius writes are always taken
	assign cfg_ready = 1'b1;

	// Controller
	cwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.status    (status),
		.smp_ready (smp_ready),
		.cmd       (cmd)
	);

	// Datapath
	cwa_datapath #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.smp_item  (smp_item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

// ===== hw/rtl/cwa_checker.sv =====
// Port-level checks for the centered window average unit, bound to the top level.
// Depends on cwa_pkg and centered_window_average_unit.
module cwa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              smp_valid,
	input logic              smp_ready,
	input cwa_pkg::in_item_t smp_item,
	input logic              res_valid,
	input logic              res_ready,
	input cwa_pkg::result_t  res_item
);
	import cwa_pkg::*;

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed or dropped while stalled");

	// The block is busy in the cycle after it takes an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !smp_ready)
		else $error("item accepted in back-to-back cycles");

	// End of stream is always the end of a run
	a_stream_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !res_item.stream_end || res_item.run_end)
		else $error("stream_end without run_end");

	// The only negative average is -1
	a_minus_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.average[AVG_W-1] |-> res_item.average == '1)
		else $error("negative average other than -1");

	// Taking a final sample never goes without a result
	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready && smp_item.final_sample |=> !smp_ready ##1 !smp_ready)
		else $error("final sample finished without a result");

endmodule

bind centered_window_average_unit cwa_checker u_cwa_checker (.*);

// ===== sim/tb_centered_window_average_unit.sv =====
// Testbench for centered_window_average_unit: directed and random sample streams
// checked against a predictor of the centered moving average held in a small scoreboard.
// Depends on cwa_pkg and the RTL of centered_window_average_unit.
`timescale 1ns / 100ps

module tb_centered_window_average_unit;
	import cwa_pkg::*;

	localparam int DEPTH          = 2 * MAX_RADIUS_DEF + 1;
	localparam int SEEN_CAP       = DEPTH + 1;
	localparam int RANDOM_ITEMS   = 480;
	localparam int MAX_IDLE       = 14;
	localparam int QUIET_CYCLES   = SUM_W + 20;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;
	localparam logic [AVG_W-1:0] NO_AVERAGE = '1;

	// Predicts window averages per accepted sample and checks results in order
	class avg_scoreboard;
		bit [SAMPLE_BITS-1:0] store [DEPTH];
		bit [SUM_W-1:0]       win_sum;
		int                   seen;
		int                   wslot;
		int                   radius;
		result_t              expected_avgs [$];
		int                   errors;

		function new();
			win_sum = '0;
			seen    = 0;
			wslot   = 0;
			radius  = 1;
			errors  = 0;
		endfunction

		function void set_radius(logic [RADIUS_W-1:0] value);
			radius = (value > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(value);
		endfunction

		function int pending();
			return expected_avgs.size();
		endfunction

		// Advance the window by one sample and queue the results it causes
		function void predict_averages(in_item_t it);
			int      k;
			int      win;
			int      n;
			int      slot;
			int      trail;
			int      total;
			int      cnt;
			int      quot;
			bit      fin;
			bit      have_center;
			result_t r;
			k           = radius;
			win         = 2 * k + 1;
			n           = seen;
			fin         = it.final_sample;
			have_center = (n >= k);
			// drop the oldest sample once the window is full
			if (n >= win) begin
				slot    = (wslot + DEPTH - win) % DEPTH;
				win_sum = win_sum - store[slot];
			end
			win_sum      = win_sum + it.sample;
			store[wslot] = it.sample;
			wslot        = (wslot + 1) % DEPTH;
			if (seen < SEEN_CAP)
				seen++;
			trail = 0;
			if (fin)
				trail = (n + 1 < k) ? n + 1 : k;
			total = int'(have_center) + trail;
			cnt   = 0;
			// result for the center position
			if (have_center) begin
				if (n + 1 >= win) begin
					quot = int'(win_sum) / win;
					if (quot > AVG_MAX)
						quot = AVG_MAX;
					r.average = AVG_W'(quot);
				end else begin
					r.average = NO_AVERAGE;
				end
				cnt++;
				r.run_end    = (cnt == total);
				r.stream_end = fin && (cnt == total);
				expected_avgs.push_back(r);
			end
			// trailing positions after the last sample
			for (int i = 0; i < trail; i++) begin
				cnt++;
				r.average    = NO_AVERAGE;
				r.run_end    = (cnt == total);
				r.stream_end = fin && (cnt == total);
				expected_avgs.push_back(r);
			end
			if (fin) begin
				win_sum = '0;
				seen    = 0;
				wslot   = 0;
			end
		endfunction

		function void check_average(result_t got);
			result_t exp_r;
			if (expected_avgs.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: average %0d run_end %0b stream_end %0b",
						got.average, got.run_end, got.stream_end);
				return;
			end
			exp_r = expected_avgs.pop_front();
			if (got.average !== exp_r.average || got.run_end !== exp_r.run_end ||
					got.stream_end !== exp_r.stream_end) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch: expected avg %0d run %0b end %0b, got avg %0d run %0b end %0b",
						exp_r.average, exp_r.run_end, exp_r.stream_end,
						got.average, got.run_end, got.stream_end);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                smp_valid;
	logic                smp_ready;
	in_item_t            smp_item;
	logic                res_valid;
	logic                res_ready;
	result_t             res_item;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [RADIUS_W-1:0] cfg_data;

	avg_scoreboard sb;
	bit            calm;
	bit            hold_req;
	int            sent;
	int            stall_cycles = 0;

	always #5 clk = ~clk;

	centered_window_average_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.smp_item  (smp_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	function int pick_wait();
		return calm ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// Offer one sample; returns at the falling edge after it is taken
	task automatic send_item(logic [SAMPLE_BITS-1:0] value, bit fin);
		int gap;
		gap = pick_wait();
		if (gap > 0) begin
			smp_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp_item.sample       = value;
		smp_item.final_sample = fin;
		smp_valid             = 1'b1;
		do @(posedge clk); while (!smp_ready);
		sb.predict_averages(smp_item);
		sent++;
		@(negedge clk);
	endtask

	// Let every expected result arrive, then give the block time to settle
	task automatic drain();
		smp_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_radius(logic [RADIUS_W-1:0] value);
		drain();
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_radius(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_stream(int len, bit close);
		logic [SAMPLE_BITS-1:0] value;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 7))
				0:       value = '1;
				1:       value = '0;
				default: value = SAMPLE_BITS'($urandom);
			endcase
			send_item(value, close && (i == len - 1));
		end
	endtask

	function int pick_radius();
		case ($urandom_range(0, 9))
			0, 1:    return 0;
			2, 3:    return MAX_RADIUS_DEF;
			4, 5, 6: return $urandom_range(1, 4);
			default: return $urandom_range(0, MAX_RADIUS_DEF);
		endcase
	endfunction

	// Stream lengths: mostly around one window, some long enough to saturate
	function int pick_length(int k);
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(DEPTH, DEPTH + 25);
		return $urandom_range(1, 2 * k + 1 + 16);
	endfunction

	// Stimulus
	initial begin
		int rad;
		int nstreams;
		arst_n    = 1'b0;
		smp_valid = 1'b0;
		smp_item  = '0;
		res_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		sent      = 0;
		sb        = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single final sample at the reset radius
		send_item(16'h1234, 1'b1);
		// short full stream at radius one
		send_item(16'h0000, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h0000, 1'b1);
		// radius zero: every sample is its own window
		write_radius(0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h0000, 1'b0);
		send_item(16'h5A5A, 1'b1);
		// largest radius with a stream shorter than the window
		write_radius(RADIUS_W'(MAX_RADIUS_DEF));
		send_item(16'hFFFF, 1'b0);
		send_item(16'h0000, 1'b0);
		send_item(16'hAAAA, 1'b0);
		send_item(16'h5555, 1'b0);
		send_item(16'hFFFF, 1'b1);
		// shrink the radius mid-stream so the kept sum overflows the average
		write_radius(3);
		repeat (7) send_item(16'hFFFF, 1'b0);
		write_radius(0);
		send_item(16'h0000, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h8000, 1'b1);

		// random phases, each under a fresh radius
		for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
			rad = pick_radius();
			write_radius(RADIUS_W'(rad));
			calm = ($urandom_range(0, 3) == 0);
			if (phase == 1) begin
				calm     = 1'b1;
				hold_req = 1'b1;
			end
			nstreams = $urandom_range(1, 3);
			for (int s = 0; s < nstreams && sent < RANDOM_ITEMS; s++)
				send_stream(pick_length(rad),
					!(s == nstreams - 1 && $urandom_range(0, 5) == 0));
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req  = 1'b0;
				res_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = pick_wait();
			if (stall > 0) begin
				res_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready = 1'b1;
			do @(posedge clk); while (!res_valid);
			sb.check_average(res_item);
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((smp_valid && smp_ready) || (res_valid && res_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
